// ===== rtl/core/bole_pkg.sv =====
// Shared types and constants of the bounded ordered list engine.
// No dependencies; imported by every module of the block.
package bole_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_REMOVE     = 3'd3,
        REQ_SEARCH     = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SC_RD,
        S_SC_CMP,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_DONE
    } seq_state_t;

    // Result of the shared comparator.
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// ===== rtl/core/bole_mem.sv =====
// Entry store of the list: one write port and one read port with registered read data.
// Depends on bole_pkg.
module bole_mem
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bole_cmp.sv =====
// Shared comparator: equality and signed less-than on two 32-bit values.
// Depends on bole_pkg.
module bole_cmp
    import bole_pkg::*;
(
    input  logic [VALUE_W-1:0] op_a,
    input  logic [VALUE_W-1:0] op_b,
    output cmp_res_t           res
);

    assign res.eq = (op_a == op_b);
    assign res.lt = ($signed(op_a) < $signed(op_b));

endmodule

// ===== rtl/core/bole_seq.sv =====
// Sequencer of the list engine: scans the store through the shared comparator,
// moves entries one at a time, and holds the result register. Depends on bole_pkg.
module bole_seq
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    in_req,
    input  logic [VALUE_W-1:0]  in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [COUNT_W-1:0]  out_count,
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output logic [VALUE_W-1:0]  mem_wr_data,
    output logic [AW-1:0]       mem_rd_addr,
    input  logic [VALUE_W-1:0]  mem_rd_data,
    output logic [VALUE_W-1:0]  cmp_a,
    output logic [VALUE_W-1:0]  cmp_b,
    input  cmp_res_t            cmp_res
);

    seq_state_t          state_reg, state_next;
    req_t                req_reg, req_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       pos_reg, pos_next;
    status_t             st_reg, st_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                is_ins;
    logic                hit;
    logic [CW-1:0]       idx_inc, idx_dec;
    logic [CW:0]         idx_inc2;
    logic [CW+COUNT_W-1:0] occ_ext;

    assign is_ins   = (req_reg == REQ_PUSH_FRONT) || (req_reg == REQ_PUSH_BACK) ||
                      (req_reg == REQ_INSERT);
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign idx_inc2 = {1'b0, idx_reg} + (CW+1)'(2);
    assign occ_ext  = {{COUNT_W{1'b0}}, occ_reg};

    // Ordered insert tests value < head at position zero, then entry >= value further on.
    always_comb begin
        if (req_reg == REQ_INSERT && idx_reg == '0) begin
            cmp_a = val_reg;
            cmp_b = mem_rd_data;
        end else begin
            cmp_a = mem_rd_data;
            cmp_b = val_reg;
        end
        if (req_reg == REQ_INSERT) begin
            hit = (idx_reg == '0) ? cmp_res.lt : !cmp_res.lt;
        end else begin
            hit = cmp_res.eq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        val_next        = val_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        in_ready        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg[AW-1:0];
        mem_wr_data     = mem_rd_data;
        mem_rd_addr     = idx_reg[AW-1:0];

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next   = req_t'(in_req);
                    val_next   = in_value;
                    st_next    = ST_DONE;
                    state_next = S_START;
                end
            end
            S_START: begin
                idx_next = '0;
                if (is_ins && occ_reg >= CW'(CAPACITY)) begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    case (req_reg)
                        REQ_PUSH_FRONT: begin
                            pos_next   = '0;
                            idx_next   = occ_reg;
                            state_next = (occ_reg == '0) ? S_PUT : S_SH_RD;
                        end
                        REQ_PUSH_BACK: begin
                            pos_next   = occ_reg;
                            state_next = S_PUT;
                        end
                        REQ_INSERT: begin
                            pos_next   = '0;
                            state_next = (occ_reg == '0) ? S_PUT : S_SC_RD;
                        end
                        REQ_REMOVE, REQ_SEARCH: begin
                            if (occ_reg == '0) begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SC_RD;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SC_RD: begin
                mem_rd_addr = idx_reg[AW-1:0];
                state_next  = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (hit) begin
                    pos_next = idx_reg;
                    if (req_reg == REQ_INSERT) begin
                        idx_next   = occ_reg;
                        state_next = S_SH_RD;
                    end else if (req_reg == REQ_SEARCH) begin
                        state_next = S_DONE;
                    end else if (idx_inc < occ_reg) begin
                        state_next = S_SH_RD;
                    end else begin
                        occ_next   = occ_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end else if (idx_inc < occ_reg) begin
                    idx_next   = idx_inc;
                    state_next = S_SC_RD;
                end else if (req_reg == REQ_INSERT) begin
                    pos_next   = occ_reg;
                    state_next = S_PUT;
                end else begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
            end
            S_SH_RD: begin
                mem_rd_addr = is_ins ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
                state_next  = S_SH_WR;
            end
            S_SH_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = mem_rd_data;
                if (is_ins) begin
                    idx_next   = idx_dec;
                    state_next = (idx_dec == pos_reg) ? S_PUT : S_SH_RD;
                end else begin
                    idx_next = idx_inc;
                    if (idx_inc2 < {1'b0, occ_reg}) begin
                        state_next = S_SH_RD;
                    end else begin
                        occ_next   = occ_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_PUT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg[AW-1:0];
                mem_wr_data = val_reg;
                occ_next    = occ_reg + 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_count_next  = occ_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: stream ports, sequencer, comparator, store.
// Depends on bole_pkg, bole_seq, bole_cmp and bole_mem.
//
// The engine keeps up to CAPACITY signed 32-bit values in a list and serves one
// request per input beat: push front, push back, ordered insert, remove of the
// first occurrence, or search. Every request gives exactly one result beat with
// a status (done or found, not found, list full) and the entry count after the
// request. A request is served by a small sequencer that walks the entry store
// one position at a time: each scanned entry takes a store read, then one pass
// through the shared comparator, and each entry that must move takes a read,
// then a write one place over; a new entry is written in a step of its own.
// A full list, the unused request codes and a lookup on an empty list go
// straight to the result, and push back writes its entry with no scan or move.
// The slowest case is an ordered insert that lands before an existing entry of
// a list holding CAPACITY - 1 entries. The store's single read port and single
// write port are why entries are read and moved one at a time. s_tready is high
// only while the sequencer is idle, so one request is in flight at a time, but a
// finished result waits in its own output register and the next request can be
// accepted while that result is not yet taken. That next request then waits in
// its result state until the output register is free again.
// No clearing pass follows reset: entries are only read below the count.
module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [2:0] req_type, [34:3] value, [39:35] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [1:0] status, [6:2] entry_count, [7] zero
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [REQ_W-1:0]    s_req_type;
    logic [VALUE_W-1:0]  s_value;
    logic [STATUS_W-1:0] m_status;
    logic [COUNT_W-1:0]  m_entry_count;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [VALUE_W-1:0]  mem_wr_data;
    logic [AW-1:0]       mem_rd_addr;
    logic [VALUE_W-1:0]  mem_rd_data;
    logic [VALUE_W-1:0]  cmp_a, cmp_b;
    cmp_res_t            cmp_res;

    // Unpack the request beat; the pad bits above the value are ignored.
    assign s_req_type = s_tdata[REQ_W-1:0];
    assign s_value    = s_tdata[REQ_W+VALUE_W-1:REQ_W];

    // Pack the result beat with a zero pad bit on top.
    assign m_tdata = {1'b0, m_entry_count, m_status};

    bole_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (s_req_type),
        .in_value    (s_value),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_status),
        .out_count   (m_entry_count),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .cmp_a       (cmp_a),
        .cmp_b       (cmp_b),
        .cmp_res     (cmp_res)
    );

    // The single comparator serves ordered placement, removal and search.
    bole_cmp u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .res  (cmp_res)
    );

    bole_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== rtl/core/bole_chk.sv =====
// Port-level checker of the bounded ordered list engine, with its bind statement.
// Depends on bole_pkg and the top level bounded_ordered_list_engine.
module bole_chk
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds its valid and data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The engine is not ready again in the cycle right after it accepts a request.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("engine ready right after accepting a request");

    // The status code is one of the three defined ones.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // A list-full status reports a count equal to the capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[6:2] == COUNT_W'(CAPACITY))
        else $error("list full reported with a count below capacity");

    // The count never exceeds the capacity; checked only for a capacity of at most 31.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 31) || (32'(m_tdata[6:2]) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind bounded_ordered_list_engine bole_chk #(
    .CAPACITY (CAPACITY)
) u_bole_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
